### rtl/fma_pkg.sv
// ----------------------------------------------------------------------------
// fma_pkg
// Types and fixed constants shared by the forward moving average block.
// ----------------------------------------------------------------------------
package fma_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int TAG_BITS     = 16;
  localparam int CFG_BITS     = 7;
  localparam int WINDOW_RESET = 10;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic        [TAG_BITS-1:0]    position;
    logic                          end_of_record;
  } sample_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic        [TAG_BITS-1:0]    out_position;
    logic                          last_of_run;
  } result_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic        [TAG_BITS-1:0]    position;
  } ring_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } fma_state_t;

endpackage

### rtl/fma_ring.sv
// ----------------------------------------------------------------------------
// fma_ring
// Ring storage for held samples and their tags: one write port, one read
// port with registered read data.
// ----------------------------------------------------------------------------
module fma_ring #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  fma_pkg::ring_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output fma_pkg::ring_entry_t rd_data
);
  import fma_pkg::*;

  ring_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/fma_div.sv
// ----------------------------------------------------------------------------
// fma_div
// Bit-serial restoring divider: signed dividend by unsigned nonzero divisor,
// one quotient bit per cycle, result truncated toward zero.
// ----------------------------------------------------------------------------
module fma_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  output logic                    busy,
  output logic signed [NUM_W-1:0] quotient
);
  import fma_pkg::*;

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic             neg;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial    = {rem, quo[NUM_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = (trial >= {1'b0, dvs});
  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem <= '0;
      dvs <= den;
      neg <= num[NUM_W-1];
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

### rtl/forward_moving_average_top.sv
// ----------------------------------------------------------------------------
// forward_moving_average_top
// Forward-looking boxcar average over a window of up to MAX_WINDOW samples.
// ----------------------------------------------------------------------------
// Channels: sample_* (valid/ready) carries a sample, its position tag and an
// end-of-record flag; result_* (valid/ready) carries the average, the tag of
// the oldest sample of the averaged window and a last-of-record flag;
// cfg_* (valid/ready) writes the window length (0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW) and drops any held samples.
// Once the window is full, each sample gives one result; the last sample of
// a record flushes shrinking windows, so a record of K samples gives K results.
// Timing: a sample that gives no result leaves the block idle. Each result
// steps through ring read and divider load, the divide at one quotient bit per
// cycle, a state that sees the divider done and the output register load;
// no sample is taken meanwhile, and a flush repeats these steps per result.
// A result waits in the output register while the receiver stalls; sample
// transfers that give no result continue meanwhile, the next result waits.
// Reset: window length 10, ring empty, no result pending; the ring needs no
// clearing pass.
// ----------------------------------------------------------------------------
module forward_moving_average_top #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  fma_pkg::sample_item_t sample_data,
  output logic                  result_valid,
  input  logic                  result_ready,
  output fma_pkg::result_item_t result_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [fma_pkg::CFG_BITS-1:0] cfg_data
);
  import fma_pkg::*;

  localparam int PW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int EFF_RESET = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

  fma_state_t state, state_next;

  logic [CW-1:0]          eff_window;
  logic [CW-1:0]          fill;
  logic [PW-1:0]          oldest;
  logic signed [SUMW-1:0] sum;
  logic                   flushing;

  logic sample_xfer, cfg_xfer, load_result;
  logic ring_rd_en, div_start, div_busy;
  logic signed [SUMW-1:0] quotient;
  ring_entry_t            rd_entry;
  ring_entry_t            wr_entry;
  logic [PW:0]            wr_sum;
  logic [PW-1:0]          wr_addr;
  logic [CW-1:0]          fill_inc;
  logic signed [SUMW-1:0] in_ext, old_ext;

  assign sample_xfer = sample_valid & sample_ready;
  assign cfg_xfer    = cfg_valid & cfg_ready;
  assign fill_inc    = fill + 1'b1;
  assign wr_sum      = (PW+1)'(oldest) + (PW+1)'(fill);
  assign wr_addr     = (wr_sum >= (PW+1)'(MAX_WINDOW)) ?
                       PW'(wr_sum - (PW+1)'(MAX_WINDOW)) : PW'(wr_sum);
  assign wr_entry    = '{sample: sample_data.sample, position: sample_data.position};
  assign in_ext  = {{(SUMW-SAMPLE_BITS){sample_data.sample[SAMPLE_BITS-1]}},
                    sample_data.sample};
  assign old_ext = {{(SUMW-SAMPLE_BITS){rd_entry.sample[SAMPLE_BITS-1]}},
                    rd_entry.sample};

  fma_ring #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (PW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (sample_xfer),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (ring_rd_en),
    .rd_addr (oldest),
    .rd_data (rd_entry)
  );

  fma_div #(
    .NUM_W (SUMW),
    .DEN_W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (sum),
    .den      (fill),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_xfer && (sample_data.end_of_record || fill_inc >= eff_window)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_result) begin
          state_next = (flushing && fill != CW'(1)) ? ST_LOAD : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    sample_ready = 1'b0;
    cfg_ready    = 1'b0;
    ring_rd_en   = 1'b0;
    div_start    = 1'b0;
    load_result  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cfg_ready    = 1'b1;
        sample_ready = ~cfg_valid;
      end
      ST_LOAD: begin
        ring_rd_en = 1'b1;
        div_start  = 1'b1;
      end
      ST_DIV: ;
      ST_EMIT: load_result = ~result_valid | result_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      eff_window   <= CW'(EFF_RESET);
      fill         <= '0;
      oldest       <= '0;
      sum          <= '0;
      flushing     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_xfer) begin
        if (cfg_data == '0) begin
          eff_window <= CW'(1);
        end else if (int'(cfg_data) > MAX_WINDOW) begin
          eff_window <= CW'(MAX_WINDOW);
        end else begin
          eff_window <= CW'(cfg_data);
        end
        fill   <= '0;
        oldest <= '0;
        sum    <= '0;
      end else if (sample_xfer) begin
        fill     <= fill_inc;
        sum      <= sum + in_ext;
        flushing <= sample_data.end_of_record;
      end else if (load_result) begin
        if (flushing && fill == CW'(1)) begin
          // record done: window restarts empty
          fill     <= '0;
          oldest   <= '0;
          sum      <= '0;
          flushing <= 1'b0;
        end else begin
          fill   <= fill - 1'b1;
          sum    <= sum - old_ext;
          oldest <= (oldest == PW'(MAX_WINDOW - 1)) ? '0 : oldest + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result_data.average      <= quotient[SAMPLE_BITS-1:0];
      result_data.out_position <= rd_entry.position;
      result_data.last_of_run  <= flushing && (fill == CW'(1));
    end
  end

  a_idle_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (fill < eff_window))
    else $error("window full while idle");

  a_idle_no_flush: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !flushing)
    else $error("flush left pending");

  a_emit_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !div_busy)
    else $error("result taken before divide finished");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (load_result && flushing && fill == CW'(1)) |=> (fill == '0 && sum == '0))
    else $error("ring not empty after last result");

endmodule
